// ===== src/tel_pkg.sv =====
// ----------------------------------------------------------------------------
// tel_pkg: shared types and constants for the timestamped event log
// Holds the operation codes, the stored entry layout and the field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package tel_pkg;

  localparam int LOG_DEPTH_DEF = 4096;

  localparam int STAMP_W = 64;
  localparam int KIND_W  = 8;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 12;
  localparam int CNT_W   = 13;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_SEEK   = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [KIND_W-1:0]  kind;
    logic [DATA_W-1:0]  data;
  } entry_t;

endpackage

`default_nettype wire

// ===== src/timestamped_event_log.sv =====
// ----------------------------------------------------------------------------
// timestamped_event_log: fixed-capacity event log with lower-bound seek
// Append and clear strobe their result in the cycle after the transfer; read
//   registers the memory data, then the result; seek waits on the search.
// Throughput: append and clear take one item a cycle; read and seek hold busy
//   until the result is loaded, set by the single memory read port.
// Reset clears state, entry count and result strobe; memory needs no clearing.
// The receiver cannot stall: each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamped_event_log import tel_pkg::*; #(
  parameter int LOG_DEPTH = LOG_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_op,
  input  wire logic [STAMP_W-1:0] in_stamp,
  input  wire logic [KIND_W-1:0]  in_event_kind,
  input  wire logic [DATA_W-1:0]  in_event_data,
  input  wire logic [IDX_W-1:0]   in_read_index,
  output logic                    out_valid,
  output logic                    out_ok,
  output logic [CNT_W-1:0]        out_position,
  output logic [STAMP_W-1:0]      out_entry_stamp,
  output logic [KIND_W-1:0]       out_entry_kind,
  output logic [DATA_W-1:0]       out_entry_data,
  output logic [CNT_W-1:0]        out_fill_count
);

  localparam int AW   = $clog2(LOG_DEPTH);
  localparam int CW   = $clog2(LOG_DEPTH + 1);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
  localparam int XW   = AW + IDX_W;

  // Control sequencer: idle takes items; read and seek wait on the memory.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_SEEK = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               rd_ok_r, rd_ok_nxt;
  logic               valid_r, valid_nxt;
  logic               ok_r, ok_nxt;
  logic [CNT_W-1:0]   pos_r, pos_nxt;
  logic [STAMP_W-1:0] es_r, es_nxt;
  logic [KIND_W-1:0]  ek_r, ek_nxt;
  logic [DATA_W-1:0]  ed_r, ed_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;

  op_t                op;
  logic               accept;
  logic               full;
  logic               read_ok;
  logic [XW-1:0]      idx_ext;

  logic               wr_en;
  entry_t             wr_entry;
  logic               mem_rd_en;
  logic [AW-1:0]      mem_rd_addr;
  entry_t             rd_entry;

  logic               seek_start;
  logic               seek_rd_en;
  logic [AW-1:0]      seek_rd_addr;
  logic               seek_done;
  logic [CW-1:0]      seek_pos;

  // An item transfers when start is high and the sequencer is idle.
  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign op      = op_t'(in_op);
  assign full    = (count_r == CW'(LOG_DEPTH));
  // Held entries sit below the count, and the count never exceeds the depth.
  assign read_ok = CMPW'(in_read_index) < CMPW'(count_r);
  assign idx_ext = XW'(in_read_index);

  // Append writes the next free slot; no read of that slot can be in flight,
  // since reads only start on later transfers.
  assign wr_en    = accept && (op == OP_APPEND) && !full;
  assign wr_entry = '{stamp: in_stamp, kind: in_event_kind, data: in_event_data};

  // Share the single read port: read op at its transfer, seek probes later.
  assign seek_start  = accept && (op == OP_SEEK);
  assign mem_rd_en   = (accept && (op == OP_READ) && read_ok) || seek_rd_en;
  assign mem_rd_addr = seek_rd_en ? seek_rd_addr : idx_ext[AW-1:0];

  tel_store #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (count_r[AW-1:0]),
    .wr_entry (wr_entry),
    .rd_en    (mem_rd_en),
    .rd_addr  (mem_rd_addr),
    .rd_entry (rd_entry)
  );

  tel_seek #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_seek (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (seek_start),
    .key      (in_stamp),
    .count    (count_r),
    .rd_stamp (rd_entry.stamp),
    .rd_en    (seek_rd_en),
    .rd_addr  (seek_rd_addr),
    .done     (seek_done),
    .position (seek_pos)
  );

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    rd_ok_nxt = rd_ok_r;
    valid_nxt = 1'b0;
    ok_nxt    = ok_r;
    pos_nxt   = pos_r;
    es_nxt    = es_r;
    ek_nxt    = ek_r;
    ed_nxt    = ed_r;
    fill_nxt  = fill_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_APPEND: begin
              // Drop the entry when full; the count holds.
              count_nxt = full ? count_r : count_r + CW'(1);
              valid_nxt = 1'b1;
              ok_nxt    = !full;
              pos_nxt   = '0;
              es_nxt    = '0;
              ek_nxt    = '0;
              ed_nxt    = '0;
              fill_nxt  = CNT_W'(count_nxt);
            end
            OP_CLEAR: begin
              // Empty the log; memory contents stay.
              count_nxt = '0;
              valid_nxt = 1'b1;
              ok_nxt    = 1'b1;
              pos_nxt   = '0;
              es_nxt    = '0;
              ek_nxt    = '0;
              ed_nxt    = '0;
              fill_nxt  = '0;
            end
            OP_READ: begin
              rd_ok_nxt = read_ok;
              state_nxt = ST_READ;
            end
            OP_SEEK: begin
              state_nxt = ST_SEEK;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_READ: begin
        // Memory data is valid now; zero the fields on a miss.
        valid_nxt = 1'b1;
        ok_nxt    = rd_ok_r;
        pos_nxt   = '0;
        es_nxt    = rd_ok_r ? rd_entry.stamp : '0;
        ek_nxt    = rd_ok_r ? rd_entry.kind  : '0;
        ed_nxt    = rd_ok_r ? rd_entry.data  : '0;
        fill_nxt  = CNT_W'(count_r);
        state_nxt = ST_IDLE;
      end
      ST_SEEK: begin
        if (seek_done) begin
          valid_nxt = 1'b1;
          ok_nxt    = 1'b1;
          pos_nxt   = CNT_W'(seek_pos);
          es_nxt    = '0;
          ek_nxt    = '0;
          ed_nxt    = '0;
          fill_nxt  = CNT_W'(count_r);
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ok_r <= rd_ok_nxt;
    ok_r    <= ok_nxt;
    pos_r   <= pos_nxt;
    es_r    <= es_nxt;
    ek_r    <= ek_nxt;
    ed_r    <= ed_nxt;
    fill_r  <= fill_nxt;
  end

  assign out_valid       = valid_r;
  assign out_ok          = ok_r;
  assign out_position    = pos_r;
  assign out_entry_stamp = es_r;
  assign out_entry_kind  = ek_r;
  assign out_entry_data  = ed_r;
  assign out_fill_count  = fill_r;

  // The count never runs past the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(LOG_DEPTH))
    else $error("entry count exceeds capacity");

  // A read result is always delivered the cycle after the memory returns.
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> out_valid)
    else $error("read result not strobed");

  // The search only finishes while the sequencer waits on it.
  a_seek_owner: assert property (@(posedge clk) disable iff (!rst_n)
    seek_done |-> (state_r == ST_SEEK))
    else $error("seek finished outside seek state");

  // An append into a full log reports failure and keeps the count.
  a_full_append: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (op == OP_APPEND) && full) |=> (out_valid && !out_ok && $stable(count_r)))
    else $error("append into full log not rejected");

endmodule

`default_nettype wire

// ===== src/tel_store.sv =====
// ----------------------------------------------------------------------------
// tel_store: entry memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tel_store import tel_pkg::*; #(
  parameter int  LOG_DEPTH = LOG_DEPTH_DEF,
  localparam int AW        = $clog2(LOG_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_entry,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_entry
);

  entry_t mem_r [LOG_DEPTH];
  entry_t rd_entry_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry_r <= mem_r[rd_addr];
    end
  end

  assign rd_entry = rd_entry_r;

endmodule

`default_nettype wire

// ===== src/tel_seek.sv =====
// ----------------------------------------------------------------------------
// tel_seek: lower-bound search sequencer
// Issue one memory probe per cycle; narrow the lo/hi window on each return.
// ----------------------------------------------------------------------------
`default_nettype none

module tel_seek import tel_pkg::*; #(
  parameter int  LOG_DEPTH = LOG_DEPTH_DEF,
  localparam int AW        = $clog2(LOG_DEPTH),
  localparam int CW        = $clog2(LOG_DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [STAMP_W-1:0] key,
  input  wire logic [CW-1:0]      count,
  input  wire logic [STAMP_W-1:0] rd_stamp,
  output logic                    rd_en,
  output logic [AW-1:0]           rd_addr,
  output logic                    done,
  output logic [CW-1:0]           position
);

  logic [STAMP_W-1:0] key_r, key_nxt;
  logic [CW-1:0]      lo_r, lo_nxt;
  logic [CW-1:0]      hi_r, hi_nxt;
  logic [AW-1:0]      mid_r, mid_nxt;
  logic               probe_r, probe_nxt;
  logic               done_r, done_nxt;

  logic               less;
  logic [CW-1:0]      lo_c, hi_c, span_c, mid_c;
  logic               issue;

  always_comb begin
    less = rd_stamp < key_r;
    if (start) begin
      lo_c = '0;
      hi_c = count;
    end else if (less) begin
      lo_c = CW'(mid_r) + CW'(1);
      hi_c = hi_r;
    end else begin
      lo_c = lo_r;
      hi_c = CW'(mid_r);
    end
    span_c = hi_c - lo_c;
    mid_c  = lo_c + (span_c >> 1);
    issue  = (start || probe_r) && (lo_c < hi_c);

    key_nxt   = start ? key : key_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    probe_nxt = 1'b0;
    done_nxt  = 1'b0;
    if (start || probe_r) begin
      lo_nxt    = lo_c;
      hi_nxt    = hi_c;
      mid_nxt   = mid_c[AW-1:0];
      probe_nxt = issue;
      done_nxt  = !issue;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      probe_r <= probe_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
  end

  assign rd_en    = issue;
  assign rd_addr  = mid_c[AW-1:0];
  assign done     = done_r;
  assign position = lo_r;

endmodule

`default_nettype wire

// ===== verif/event_log_checker.sv =====
// ----------------------------------------------------------------------------
// event_log_checker: result predictor and comparator for the event log
// Watches the command and result channels, replays every accepted command
// against a private copy of the log and matches each result strobe against
// the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module event_log_checker import tel_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic [1:0]         in_op,
  input  wire logic [STAMP_W-1:0] in_stamp,
  input  wire logic [KIND_W-1:0]  in_event_kind,
  input  wire logic [DATA_W-1:0]  in_event_data,
  input  wire logic [IDX_W-1:0]   in_read_index,
  input  wire logic               out_valid,
  input  wire logic               out_ok,
  input  wire logic [CNT_W-1:0]   out_position,
  input  wire logic [STAMP_W-1:0] out_entry_stamp,
  input  wire logic [KIND_W-1:0]  out_entry_kind,
  input  wire logic [DATA_W-1:0]  out_entry_data,
  input  wire logic [CNT_W-1:0]   out_fill_count,
  output int unsigned             mismatch_count,
  output int unsigned             pending_count
);

  typedef struct packed {
    logic               ok;
    logic [CNT_W-1:0]   position;
    logic [STAMP_W-1:0] stamp;
    logic [KIND_W-1:0]  kind;
    logic [DATA_W-1:0]  data;
    logic [CNT_W-1:0]   fill;
  } log_result_t;

  logic [STAMP_W-1:0] stamp_mem [LOG_DEPTH_DEF];
  logic [KIND_W-1:0]  kind_mem  [LOG_DEPTH_DEF];
  logic [DATA_W-1:0]  data_mem  [LOG_DEPTH_DEF];
  int unsigned        held_entries = 0;
  log_result_t        predicted_results [$];

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  // Apply one command to the private log and return the result it must give.
  function automatic log_result_t apply_command(op_t op, logic [STAMP_W-1:0] key,
                                                logic [KIND_W-1:0] kind,
                                                logic [DATA_W-1:0] data,
                                                logic [IDX_W-1:0] idx);
    log_result_t r;
    int unsigned lo, hi, mid;
    r = '0;
    case (op)
      OP_APPEND: begin
        if (held_entries < LOG_DEPTH_DEF) begin
          stamp_mem[held_entries] = key;
          kind_mem[held_entries]  = kind;
          data_mem[held_entries]  = data;
          held_entries++;
          r.ok = 1'b1;
        end
      end
      OP_SEEK: begin
        // halving search as the hardware runs it, sorted or not
        lo = 0;
        hi = held_entries;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (stamp_mem[mid] < key) lo = mid + 1;
          else hi = mid;
        end
        r.position = CNT_W'(lo);
        r.ok = 1'b1;
      end
      OP_READ: begin
        if (idx < held_entries) begin
          r.stamp = stamp_mem[idx];
          r.kind  = kind_mem[idx];
          r.data  = data_mem[idx];
          r.ok    = 1'b1;
        end
      end
      default: begin
        held_entries = 0;
        r.ok = 1'b1;
      end
    endcase
    r.fill = CNT_W'(held_entries);
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    log_result_t want;
    if (!rst_n) begin
      held_entries = 0;
      predicted_results.delete();
    end else begin
      // compare before recording this edge's transfer: no result is strobed in its own transfer's cycle
      if (out_valid) begin
        if (predicted_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result strobe with no transfer awaiting it", $time);
        end else begin
          want = predicted_results.pop_front();
          check_field("ok",          want.ok,       out_ok);
          check_field("position",    want.position, out_position);
          check_field("entry_stamp", want.stamp,    out_entry_stamp);
          check_field("entry_kind",  want.kind,     out_entry_kind);
          check_field("entry_data",  want.data,     out_entry_data);
          check_field("fill_count",  want.fill,     out_fill_count);
        end
      end
      if (start && !busy)
        predicted_results.push_back(apply_command(op_t'(in_op), in_stamp, in_event_kind,
                                                  in_event_data, in_read_index));
    end
    pending_count = predicted_results.size();
  end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the timestamped event log
// Drives directed corner commands, builds a long sorted run, then runs
// random append/seek/read/clear sequences with random start gaps; a checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import tel_pkg::*;

  // Random part size, and how many of its last transfers run without gaps.
  localparam int RANDOM_ITEMS = 600;
  localparam int CALM_TAIL    = 120;
  // Length of the sorted run built before the random part.
  localparam int FILL_ITEMS   = 200;
  // Drain wait, well past the worst seek.
  localparam int DRAIN_CYCLES = 40;
  localparam int DRAIN_LIMIT  = 2000;
  // Time limit for about 900 transfers with their gaps and searches, with wide margin.
  localparam int RUN_LIMIT    = 2_000_000;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               start         = 1'b0;
  logic [1:0]         in_op         = OP_CLEAR;
  logic [STAMP_W-1:0] in_stamp      = '0;
  logic [KIND_W-1:0]  in_event_kind = '0;
  logic [DATA_W-1:0]  in_event_data = '0;
  logic [IDX_W-1:0]   in_read_index = '0;
  logic               busy;
  logic               out_valid;
  logic               out_ok;
  logic [CNT_W-1:0]   out_position;
  logic [STAMP_W-1:0] out_entry_stamp;
  logic [KIND_W-1:0]  out_entry_kind;
  logic [DATA_W-1:0]  out_entry_data;
  logic [CNT_W-1:0]   out_fill_count;
  int unsigned        mismatch_count;
  int unsigned        pending_count;

  // Stimulus-side view of the stamps held, used to aim seeks and reads and to force clears.
  logic [STAMP_W-1:0] held_stamps [$];
  int unsigned        transfers_sent = 0;
  int unsigned        random_goal    = '1;
  bit                 calm           = 1'b0;
  bit                 tail           = 1'b0;

  timestamped_event_log DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_stamp        (in_stamp),
    .in_event_kind   (in_event_kind),
    .in_event_data   (in_event_data),
    .in_read_index   (in_read_index),
    .out_valid       (out_valid),
    .out_ok          (out_ok),
    .out_position    (out_position),
    .out_entry_stamp (out_entry_stamp),
    .out_entry_kind  (out_entry_kind),
    .out_entry_data  (out_entry_data),
    .out_fill_count  (out_fill_count)
  );

  event_log_checker log_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_stamp        (in_stamp),
    .in_event_kind   (in_event_kind),
    .in_event_data   (in_event_data),
    .in_read_index   (in_read_index),
    .out_valid       (out_valid),
    .out_ok          (out_ok),
    .out_position    (out_position),
    .out_entry_stamp (out_entry_stamp),
    .out_entry_kind  (out_entry_kind),
    .out_entry_data  (out_entry_data),
    .out_fill_count  (out_fill_count),
    .mismatch_count  (mismatch_count),
    .pending_count   (pending_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the handshake or the result stream hangs.
  initial begin
    #RUN_LIMIT;
    $display("[timestamped_event_log] ERROR");
    $finish;
  end

  function automatic logic [STAMP_W-1:0] rand_stamp();
    return {$urandom, $urandom};
  endfunction

  // Present one command and hold it until the block takes it. An idle burst
  // may come first; start is written once per edge, so back-to-back
  // transfers keep it high without a dip.
  task automatic transfer(op_t op, logic [STAMP_W-1:0] stamp, logic [KIND_W-1:0] kind,
                          logic [DATA_W-1:0] data, logic [IDX_W-1:0] idx);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 49) == 0) calm = !calm;
    if (!tail && !calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 13);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_op         <= op;
    in_stamp      <= stamp;
    in_event_kind <= kind;
    in_event_data <= data;
    in_read_index <= idx;
    // busy read here is the value before this edge's update: the sampled one
    do @(posedge clk); while (busy);
    case (op)
      OP_APPEND: if (held_stamps.size() < LOG_DEPTH_DEF) held_stamps.push_back(stamp);
      OP_CLEAR:  held_stamps.delete();
      default:   ;
    endcase
    transfers_sent++;
    if (transfers_sent + CALM_TAIL >= random_goal) tail = 1'b1;
  endtask

  // Unused fields carry random junk so the block is seen to ignore them.
  task automatic append_entry(logic [STAMP_W-1:0] stamp, logic [KIND_W-1:0] kind,
                              logic [DATA_W-1:0] data);
    transfer(OP_APPEND, stamp, kind, data, IDX_W'($urandom));
  endtask

  task automatic seek_stamp(logic [STAMP_W-1:0] key);
    transfer(OP_SEEK, key, KIND_W'($urandom), $urandom, IDX_W'($urandom));
  endtask

  task automatic read_entry(logic [IDX_W-1:0] idx);
    transfer(OP_READ, rand_stamp(), KIND_W'($urandom), $urandom, idx);
  endtask

  task automatic clear_log();
    transfer(OP_CLEAR, rand_stamp(), KIND_W'($urandom), $urandom, IDX_W'($urandom));
  endtask

  // Aim a seek key at held stamps, their neighbors, the range ends or a random stamp.
  function automatic logic [STAMP_W-1:0] pick_seek_key();
    logic [STAMP_W-1:0] held;
    int unsigned choice;
    choice = $urandom_range(0, 7);
    if (held_stamps.size() == 0 && choice >= 3) choice = 2;
    if (held_stamps.size() != 0) held = held_stamps[$urandom_range(0, held_stamps.size() - 1)];
    case (choice)
      0:       return '0;
      1:       return '1;
      2:       return rand_stamp();
      6:       return held - 1;
      7:       return held + 1;
      default: return held;
    endcase
  endfunction

  // One well-formed burst: optional clear, sorted appends with duplicates,
  // then a mix of queries. A few unsorted appends and raw commands are noise.
  task automatic run_sequence();
    logic [STAMP_W-1:0] nxt_stamp;
    int unsigned n_append, n_query, choice;
    if (held_stamps.size() >= 300 || $urandom_range(0, 9) < 7) clear_log();
    nxt_stamp = ($urandom_range(0, 1) == 0) ? rand_stamp() : STAMP_W'($urandom_range(0, 5000));
    n_append = $urandom_range(0, 48);
    for (int i = 0; i < n_append; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        append_entry(rand_stamp(), KIND_W'($urandom), $urandom);
      end else begin
        append_entry(nxt_stamp, KIND_W'($urandom), $urandom);
        if ($urandom_range(0, 3) != 0) nxt_stamp += $urandom_range(1, 1000);
      end
    end
    n_query = $urandom_range(4, 24);
    for (int i = 0; i < n_query; i++) begin
      choice = $urandom_range(0, 19);
      if (choice < 10) begin
        seek_stamp(pick_seek_key());
      end else if (choice < 17) begin
        if (held_stamps.size() != 0 && $urandom_range(0, 6) != 0)
          read_entry(IDX_W'($urandom_range(0, held_stamps.size() - 1)));
        else
          read_entry(IDX_W'($urandom));
      end else if (choice < 19) begin
        append_entry(nxt_stamp, KIND_W'($urandom), $urandom);
        nxt_stamp += $urandom_range(0, 50);
      end else begin
        transfer(op_t'($urandom_range(0, 3)), rand_stamp(), KIND_W'($urandom), $urandom,
                 IDX_W'($urandom));
      end
    end
  endtask

  initial begin
    logic [STAMP_W-1:0] fill_stamp;
    int unsigned drain_wait;

    // Hold reset, then release it once for the whole run.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty log, range ends of every field, duplicates, unsorted
    // seek, clear keeping contents unreadable, seek past every entry.
    seek_stamp('1);
    read_entry('0);
    read_entry('1);
    append_entry('0, 8'h00, 32'h0000_0000);
    append_entry(64'd5, 8'hFF, 32'hFFFF_FFFF);
    append_entry(64'd5, 8'h5A, 32'hA5A5_A5A5);
    append_entry('1, 8'h81, 32'h8000_0001);
    seek_stamp('0);
    seek_stamp(64'd5);
    seek_stamp(64'd6);
    seek_stamp('1);
    read_entry(12'd0);
    read_entry(12'd3);
    read_entry(12'd4);
    append_entry(64'd1, 8'h3C, 32'h1234_5678);
    seek_stamp(64'd2);
    seek_stamp('1);
    clear_log();
    read_entry(12'd0);
    seek_stamp(64'd7);
    append_entry(64'd100, 8'h01, 32'h0000_0001);
    seek_stamp(64'd101);

    // Build a long sorted run with duplicates for deeper seeks.
    clear_log();
    fill_stamp = STAMP_W'($urandom_range(0, 1000));
    for (int i = 0; i < FILL_ITEMS; i++) begin
      append_entry(fill_stamp, KIND_W'($urandom), $urandom);
      if ($urandom_range(0, 1) == 0) fill_stamp += $urandom_range(1, 1 << 20);
    end
    append_entry(rand_stamp(), KIND_W'($urandom), $urandom);
    append_entry('1, 8'hFF, 32'hFFFF_FFFF);
    append_entry('0, 8'h00, 32'h0000_0000);
    seek_stamp('0);
    seek_stamp('1);
    seek_stamp(held_stamps[0]);
    seek_stamp(held_stamps[FILL_ITEMS - 1]);
    seek_stamp(held_stamps[FILL_ITEMS / 2] + 1);
    for (int i = 0; i < 4; i++) seek_stamp(pick_seek_key());
    read_entry(12'hFFF);
    read_entry(12'h000);
    read_entry(12'h800);
    for (int i = 0; i < 4; i++) read_entry(IDX_W'($urandom));

    // Random sequences; the last stretch runs with start never dropped.
    random_goal = transfers_sent + RANDOM_ITEMS;
    while (transfers_sent < random_goal) run_sequence();

    // Stop issuing, wait for every outstanding result, then drain.
    start <= 1'b0;
    drain_wait = 0;
    while (pending_count != 0 && drain_wait < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("[timestamped_event_log] OK");
    end else begin
      if (pending_count != 0)
        $display("%0t: %0d predicted result(s) never arrived", $time, pending_count);
      $display("[timestamped_event_log] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
src/tel_pkg.sv
src/tel_store.sv
src/tel_seek.sv
src/timestamped_event_log.sv
verif/event_log_checker.sv
verif/testbench.sv
